// ===== hw/rtl/msdu_pkg.sv =====
// ----------------------------------------------------------------------------
// msdu_pkg
// Shared types, register map and helpers for the unwrapped MSD block.
// ----------------------------------------------------------------------------
package msdu_pkg;

    localparam int MAX_ATOMS_DEF = 1024;
    localparam int COORD_W       = 32;
    localparam int BOX_W         = 31;
    localparam int SQ_W          = 64;
    localparam int DIST_W        = 32;
    localparam int IDXO_W        = 10;
    localparam int CNT_W         = 11;
    localparam int ADDR_W        = 4;

    localparam logic [1:0] REG_IMAGING = 2'd0;
    localparam logic [1:0] REG_COUNT   = 2'd1;
    localparam logic [1:0] REG_PRINT   = 2'd2;

    localparam logic KIND_ATOM  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    localparam logic OP_DIV  = 1'b0;
    localparam logic OP_SQRT = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [BOX_W-1:0]   box_x;
        logic [BOX_W-1:0]   box_y;
        logic [BOX_W-1:0]   box_z;
    } msdu_item_t;

    typedef struct packed {
        logic first;
        logic fin;
        logic clr;
        logic imaging;
        logic print;
    } msdu_flags_t;

    function automatic logic [SQ_W-1:0] sat_add(input logic [SQ_W-1:0] a,
                                                input logic [SQ_W-1:0] b);
        logic [SQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/msdu_ram.sv =====
// ----------------------------------------------------------------------------
// msdu_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module msdu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/msdu_front.sv =====
// ----------------------------------------------------------------------------
// msdu_front
// Accept items, track the atom cursor, classify, and queue them for the back.
// ----------------------------------------------------------------------------
module msdu_front import msdu_pkg::*; #(
    parameter int MAX_ATOMS = MAX_ATOMS_DEF,
    localparam int IW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1,
    localparam int CW = $clog2(MAX_ATOMS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  msdu_item_t        item,
    input  logic              imaging_enable,
    input  logic [CNT_W-1:0]  atom_count,
    input  logic              print_individual,
    output logic [CW-1:0]     n_eff,
    output logic              q_valid,
    input  logic              q_pop,
    output msdu_item_t        q_item,
    output msdu_flags_t       q_flags,
    output logic [IW-1:0]     q_idx
);

    logic [IW-1:0]  cursor_reg, cursor_next;
    logic           ref_reg, ref_next;
    logic [1:0]     count_reg, count_next;
    logic           wr_ptr_reg, rd_ptr_reg;
    msdu_item_t     qi_reg [2];
    msdu_flags_t    qf_reg [2];
    logic [IW-1:0]  qx_reg [2];
    logic [31:0]    cnt_ext;
    logic [CW-1:0]  cur_ext, cur, cur_inc;
    logic           push, clr, fin;
    msdu_flags_t    flags;

    always_comb
    begin
        cnt_ext = {{(32-CNT_W){1'b0}}, atom_count};
        if (cnt_ext == 32'd0)
        begin
            cnt_ext = 32'd1;
        end
        else if (cnt_ext > 32'(MAX_ATOMS))
        begin
            cnt_ext = 32'(MAX_ATOMS);
        end
        n_eff = cnt_ext[CW-1:0];
    end

    // Drop a partial frame when the count was lowered below the cursor.
    assign cur_ext = CW'(cursor_reg);
    assign clr     = (cur_ext >= n_eff);
    assign cur     = clr ? '0 : cur_ext;
    assign cur_inc = cur + CW'(1);
    assign fin     = (cur_inc >= n_eff);

    assign item_stall = (count_reg == 2'd2);
    assign push       = item_valid && !item_stall;

    always_comb
    begin
        flags.first   = !ref_reg;
        flags.fin     = fin;
        flags.clr     = clr;
        flags.imaging = imaging_enable;
        flags.print   = print_individual;
        cursor_next   = cursor_reg;
        ref_next      = ref_reg;
        if (push)
        begin
            cursor_next = fin ? '0 : cur_inc[IW-1:0];
            if (!ref_reg && fin)
            begin
                ref_next = 1'b1;
            end
        end
        count_next = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            ref_reg    <= 1'b0;
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            ref_reg    <= ref_next;
            count_reg  <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qi_reg[wr_ptr_reg] <= item;
            qf_reg[wr_ptr_reg] <= flags;
            qx_reg[wr_ptr_reg] <= cur[IW-1:0];
        end
    end

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = qi_reg[rd_ptr_reg];
    assign q_flags = qf_reg[rd_ptr_reg];
    assign q_idx   = qx_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/msdu_seru.sv =====
// ----------------------------------------------------------------------------
// msdu_seru
// Serial unit: 64-bit by count restoring divide, or 64-bit floor square root.
// ----------------------------------------------------------------------------
module msdu_seru import msdu_pkg::*; #(
    parameter int MAX_ATOMS = MAX_ATOMS_DEF,
    localparam int CW = $clog2(MAX_ATOMS + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            op,
    input  logic [SQ_W-1:0] a,
    input  logic [CW-1:0]   d,
    output logic            done,
    output logic [SQ_W-1:0] res
);

    logic            busy_reg, done_reg, op_reg;
    logic [5:0]      cnt_reg;
    logic [SQ_W-1:0] v_reg;
    logic [CW-1:0]   d_reg, drem_reg;
    logic [32:0]     srem_reg;
    logic [31:0]     root_reg;
    logic [CW:0]     dr2;
    logic [34:0]     sr2, st;
    logic            dge, sge;

    assign dr2 = {drem_reg, v_reg[SQ_W-1]};
    assign dge = (dr2 >= {1'b0, d_reg});
    assign sr2 = {srem_reg, v_reg[SQ_W-1:SQ_W-2]};
    assign st  = {1'b0, root_reg, 2'b01};
    assign sge = (sr2 >= st);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (op == OP_SQRT) ? 6'd31 : 6'd63;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= op;
            v_reg    <= a;
            d_reg    <= d;
            drem_reg <= '0;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_SQRT)
            begin
                v_reg <= {v_reg[SQ_W-3:0], 2'b00};
                if (sge)
                begin
                    srem_reg <= 33'(sr2 - st);
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    srem_reg <= sr2[32:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            else
            begin
                v_reg    <= {v_reg[SQ_W-2:0], dge};
                drem_reg <= dge ? CW'(dr2 - {1'b0, d_reg}) : dr2[CW-1:0];
            end
        end
    end

    assign done = done_reg;
    assign res  = (op_reg == OP_SQRT) ? {32'd0, root_reg} : v_reg;

endmodule

// ===== hw/rtl/msdu_back.sv =====
// ----------------------------------------------------------------------------
// msdu_back
// Execute queued atoms: unwrap, square, accumulate, and emit results.
// ----------------------------------------------------------------------------
module msdu_back import msdu_pkg::*; #(
    parameter int MAX_ATOMS = MAX_ATOMS_DEF,
    localparam int IW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1,
    localparam int CW = $clog2(MAX_ATOMS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CW-1:0]     n_eff,
    input  logic              q_valid,
    output logic              q_pop,
    input  msdu_item_t        q_item,
    input  msdu_flags_t       q_flags,
    input  logic [IW-1:0]     q_idx,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              kind,
    output logic [IDXO_W-1:0] atom_index,
    output logic [SQ_W-1:0]   sq_x,
    output logic [SQ_W-1:0]   sq_y,
    output logic [SQ_W-1:0]   sq_z,
    output logic [SQ_W-1:0]   sq_total,
    output logic [DIST_W-1:0] distance,
    output logic              last
);

    localparam int WW = 9 * COORD_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_SUM2 = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_ASQ  = 4'd7;
    localparam logic [3:0] S_AOUT = 4'd8;
    localparam logic [3:0] S_FDIV = 4'd9;
    localparam logic [3:0] S_FDW  = 4'd10;
    localparam logic [3:0] S_FSQ  = 4'd11;
    localparam logic [3:0] S_FOUT = 4'd12;

    logic [3:0]         state_reg, state_next;
    msdu_item_t         e_item_reg;
    msdu_flags_t        e_flags_reg;
    logic [IW-1:0]      e_idx_reg;
    logic [COORD_W-1:0] sh_reg [3];
    logic [COORD_W-1:0] fi_reg [3];
    logic [31:0]        mag_reg [3];
    logic               sat_reg [3];
    logic [SQ_W-1:0]    sq_reg [3];
    logic [SQ_W-1:0]    sxy_reg, st_reg;
    logic [SQ_W-1:0]    acc_reg [4];
    logic [SQ_W-1:0]    mean_reg [4];
    logic [DIST_W-1:0]  root_reg;
    logic [1:0]         fsel_reg;
    logic               r_valid_reg;
    logic               r_kind_reg, r_last_reg;
    logic [IDXO_W-1:0]  r_idx_reg;
    logic [SQ_W-1:0]    r_sq_reg [4];
    logic [DIST_W-1:0]  r_dist_reg;

    logic               ram_we;
    logic [WW-1:0]      ram_wdata, ram_rdata;
    logic [COORD_W-1:0] rd_first [3];
    logic [COORD_W-1:0] rd_prev  [3];
    logic [COORD_W-1:0] rd_shift [3];
    logic [COORD_W-1:0] pos [3];
    logic [BOX_W-1:0]   box [3];
    logic [COORD_W-1:0] nsh [3];
    logic               slot_free, load_out;
    logic               su_start, su_op, su_done;
    logic [SQ_W-1:0]    su_a, su_res;
    logic [31:0]        idx_ext;

    function automatic logic [COORD_W-1:0] unwrap_shift(
        input logic [COORD_W-1:0] p,
        input logic [COORD_W-1:0] pv,
        input logic [COORD_W-1:0] sh,
        input logic [BOX_W-1:0]   bx,
        input logic               en
    );
        logic [32:0] stp;
        logic [33:0] s2, b2;
        stp = {p[31], p} - {pv[31], pv};
        s2  = {stp, 1'b0};
        b2  = {3'b000, bx};
        if (en && ($signed(s2) > $signed(b2)))
        begin
            return 32'(sh - {1'b0, bx});
        end
        else if (en && ($signed(s2) < -$signed(b2)))
        begin
            return 32'(sh + {1'b0, bx});
        end
        return sh;
    endfunction

    assign pos[0] = e_item_reg.pos_x;
    assign pos[1] = e_item_reg.pos_y;
    assign pos[2] = e_item_reg.pos_z;
    assign box[0] = e_item_reg.box_x;
    assign box[1] = e_item_reg.box_y;
    assign box[2] = e_item_reg.box_z;

    assign {rd_first[0], rd_first[1], rd_first[2],
            rd_prev[0], rd_prev[1], rd_prev[2],
            rd_shift[0], rd_shift[1], rd_shift[2]} = ram_rdata;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            nsh[a] = unwrap_shift(pos[a], rd_prev[a], rd_shift[a], box[a],
                                  e_flags_reg.imaging);
        end
    end

    always_comb
    begin
        ram_we    = (state_reg == S_READ);
        // Store the reference and clear the offsets on the first frame.
        if (e_flags_reg.first)
        begin
            ram_wdata = {pos[0], pos[1], pos[2], pos[0], pos[1], pos[2],
                         {(3*COORD_W){1'b0}}};
        end
        else
        begin
            ram_wdata = {rd_first[0], rd_first[1], rd_first[2],
                         pos[0], pos[1], pos[2], nsh[0], nsh[1], nsh[2]};
        end
    end

    msdu_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_ATOMS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (e_idx_reg),
        .wdata (ram_wdata),
        .re    (q_pop),
        .raddr (q_idx),
        .rdata (ram_rdata)
    );

    assign slot_free = !r_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        su_start   = 1'b0;
        su_op      = OP_DIV;
        su_a       = acc_reg[fsel_reg];
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: state_next = e_flags_reg.first ? S_IDLE : S_DISP;
            S_DISP: state_next = S_MUL;
            S_MUL:  state_next = S_SUM;
            S_SUM:  state_next = S_SUM2;
            S_SUM2: state_next = S_ACC;
            S_ACC:
            begin
                if (e_flags_reg.print)
                begin
                    su_start   = 1'b1;
                    su_op      = OP_SQRT;
                    su_a       = st_reg;
                    state_next = S_ASQ;
                end
                else
                begin
                    state_next = e_flags_reg.fin ? S_FDIV : S_IDLE;
                end
            end
            S_ASQ:
            begin
                if (su_done)
                begin
                    state_next = S_AOUT;
                end
            end
            S_AOUT:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = e_flags_reg.fin ? S_FDIV : S_IDLE;
                end
            end
            S_FDIV:
            begin
                su_start   = 1'b1;
                state_next = S_FDW;
            end
            S_FDW:
            begin
                if (su_done)
                begin
                    if (fsel_reg == 2'd3)
                    begin
                        su_start   = 1'b1;
                        su_op      = OP_SQRT;
                        su_a       = su_res;
                        state_next = S_FSQ;
                    end
                    else
                    begin
                        state_next = S_FDIV;
                    end
                end
            end
            S_FSQ:
            begin
                if (su_done)
                begin
                    state_next = S_FOUT;
                end
            end
            S_FOUT:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    msdu_seru #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_seru (
        .clk   (clk),
        .rst_n (rst_n),
        .start (su_start),
        .op    (su_op),
        .a     (su_a),
        .d     (n_eff),
        .done  (su_done),
        .res   (su_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            r_valid_reg <= 1'b0;
            fsel_reg    <= 2'd0;
            for (int k = 0; k < 4; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                r_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                r_valid_reg <= 1'b0;
            end
            if (q_pop && q_flags.clr)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    acc_reg[k] <= '0;
                end
            end
            if (state_reg == S_SUM)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    acc_reg[k] <= sat_add(acc_reg[k], sq_reg[k]);
                end
            end
            if (state_reg == S_ACC)
            begin
                acc_reg[3] <= sat_add(acc_reg[3], st_reg);
                fsel_reg   <= 2'd0;
            end
            if (state_reg == S_FDW && su_done)
            begin
                fsel_reg <= fsel_reg + 2'd1;
            end
            // Clear the accumulators once the frame result is out.
            if (state_reg == S_FOUT && load_out)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    acc_reg[k] <= '0;
                end
            end
        end
    end

    assign idx_ext = 32'(e_idx_reg);

    always_ff @(posedge clk)
    begin
        logic [33:0] dsp, mg;
        if (q_pop)
        begin
            e_item_reg  <= q_item;
            e_flags_reg <= q_flags;
            e_idx_reg   <= q_idx;
        end
        if (state_reg == S_READ)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sh_reg[a] <= nsh[a];
                fi_reg[a] <= rd_first[a];
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            dsp = {{2{pos[a][31]}}, pos[a]} + {{2{sh_reg[a][31]}}, sh_reg[a]}
                - {{2{fi_reg[a][31]}}, fi_reg[a]};
            mg  = dsp[33] ? 34'(-dsp) : dsp;
            if (state_reg == S_DISP)
            begin
                mag_reg[a] <= mg[31:0];
                sat_reg[a] <= |mg[33:32];
            end
            if (state_reg == S_MUL)
            begin
                sq_reg[a] <= sat_reg[a] ? {SQ_W{1'b1}} :
                             {32'd0, mag_reg[a]} * {32'd0, mag_reg[a]};
            end
        end
        if (state_reg == S_SUM)
        begin
            sxy_reg <= sat_add(sq_reg[0], sq_reg[1]);
        end
        if (state_reg == S_SUM2)
        begin
            st_reg <= sat_add(sxy_reg, sq_reg[2]);
        end
        if (state_reg == S_FDW && su_done)
        begin
            mean_reg[fsel_reg] <= su_res;
        end
        if ((state_reg == S_ASQ || state_reg == S_FSQ) && su_done)
        begin
            root_reg <= su_res[DIST_W-1:0];
        end
        if (load_out)
        begin
            r_dist_reg <= root_reg;
            if (state_reg == S_AOUT)
            begin
                r_kind_reg  <= KIND_ATOM;
                r_idx_reg   <= idx_ext[IDXO_W-1:0];
                r_last_reg  <= !e_flags_reg.fin;
                r_sq_reg[0] <= sq_reg[0];
                r_sq_reg[1] <= sq_reg[1];
                r_sq_reg[2] <= sq_reg[2];
                r_sq_reg[3] <= st_reg;
            end
            else
            begin
                r_kind_reg <= KIND_FRAME;
                r_idx_reg  <= '0;
                r_last_reg <= 1'b1;
                for (int k = 0; k < 4; k++)
                begin
                    r_sq_reg[k] <= mean_reg[k];
                end
            end
        end
    end

    assign result_valid = r_valid_reg;
    assign kind         = r_kind_reg;
    assign atom_index   = r_idx_reg;
    assign sq_x         = r_sq_reg[0];
    assign sq_y         = r_sq_reg[1];
    assign sq_z         = r_sq_reg[2];
    assign sq_total     = r_sq_reg[3];
    assign distance     = r_dist_reg;
    assign last         = r_last_reg;

endmodule

// ===== hw/rtl/mean_square_displacement_unwrap_core.sv =====
// Path: a later-frame atom runs READ, DISP, MUL, SUM, SUM2 and ACC, then the
//   serial root (ASQ) and the output load (AOUT) if per-atom output is on.
// Flow: a two-entry queue takes atoms while the back is busy; first-frame atoms
//   are only stored; a frame end adds four divides, a root and a load.
// Reset: rst_n clears cursor, reference flag, accumulators and control; offsets
//   are zeroed on frame one, so the coordinate store needs no clearing pass.
// ----------------------------------------------------------------------------
// mean_square_displacement_unwrap_core
// Mean square displacement with per-axis periodic image unwrapping.
// ----------------------------------------------------------------------------
module mean_square_displacement_unwrap_core import msdu_pkg::*; #(
    parameter int MAX_ATOMS = MAX_ATOMS_DEF,
    localparam int IW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1,
    localparam int CW = $clog2(MAX_ATOMS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // item channel
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [COORD_W-1:0] pos_z,
    input  logic [BOX_W-1:0]   box_len_x,
    input  logic [BOX_W-1:0]   box_len_y,
    input  logic [BOX_W-1:0]   box_len_z,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output logic               kind,
    output logic [IDXO_W-1:0]  atom_index,
    output logic [SQ_W-1:0]    sq_x,
    output logic [SQ_W-1:0]    sq_y,
    output logic [SQ_W-1:0]    sq_z,
    output logic [SQ_W-1:0]    sq_total,
    output logic [DIST_W-1:0]  distance,
    output logic               last
);

    logic              imaging_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              print_reg;
    logic              cfg_wr;
    msdu_item_t        item;
    logic [CW-1:0]     n_eff;
    logic              q_valid, q_pop;
    msdu_item_t        q_item;
    msdu_flags_t       q_flags;
    logic [IW-1:0]     q_idx;

    // Register file: write on the access phase, read back combinationally.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            imaging_reg <= 1'b0;
            count_reg   <= CNT_W'(1);
            print_reg   <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_IMAGING: imaging_reg <= pwdata[0];
                REG_COUNT:   count_reg   <= pwdata[CNT_W-1:0];
                REG_PRINT:   print_reg   <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_IMAGING: prdata = {31'd0, imaging_reg};
            REG_COUNT:   prdata = {{(32-CNT_W){1'b0}}, count_reg};
            REG_PRINT:   prdata = {31'd0, print_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign item.pos_x = pos_x;
    assign item.pos_y = pos_y;
    assign item.pos_z = pos_z;
    assign item.box_x = box_len_x;
    assign item.box_y = box_len_y;
    assign item.box_z = box_len_z;

    // Front: hold the cursor, classify each transaction, queue it.
    msdu_front #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .item             (item),
        .imaging_enable   (imaging_reg),
        .atom_count       (count_reg),
        .print_individual (print_reg),
        .n_eff            (n_eff),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_item           (q_item),
        .q_flags          (q_flags),
        .q_idx            (q_idx)
    );

    // Back: unwrap, square, accumulate, divide and root, drive results.
    msdu_back #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .n_eff        (n_eff),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .q_flags      (q_flags),
        .q_idx        (q_idx),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .atom_index   (atom_index),
        .sq_x         (sq_x),
        .sq_y         (sq_y),
        .sq_z         (sq_z),
        .sq_total     (sq_total),
        .distance     (distance),
        .last         (last)
    );

endmodule
